// ===== rtl/bcc_pkg.sv =====
// Shared types and constants for the bounded coin change block.
// Holds the microcode word format, the control program and the coin values.
// No dependencies.
`timescale 1ns / 1ps

package bcc_pkg;

  // Coin values in cents
  localparam int unsigned CENTS_QUARTER = 25;
  localparam int unsigned CENTS_DIME    = 10;
  localparam int unsigned CENTS_NICKEL  = 5;

  localparam int STEP_BITS = 3;
  typedef logic [STEP_BITS-1:0] step_t;

  // Datapath actions, one per control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_QSTART,
    OP_EVAL,
    OP_QNEXT,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE_WAIT,
    C_DIME_MORE,
    C_QUARTER_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
    step_t next;
  } ctrl_word_t;

  // Loop status from the datapath back to the sequencer
  typedef struct packed {
    logic dime_more;
    logic quarter_more;
  } dp_flags_t;

  // Program step addresses
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_DIV    = 3'd1;
  localparam step_t STEP_QSTART = 3'd2;
  localparam step_t STEP_PAIR   = 3'd3;
  localparam step_t STEP_QNEXT  = 3'd4;
  localparam step_t STEP_EMIT   = 3'd5;
  localparam step_t STEP_SPARE0 = 3'd6;
  localparam step_t STEP_SPARE1 = 3'd7;

  localparam int PROG_DEPTH = 2 ** STEP_BITS;

  // Control store: jump when the condition holds, else go to next
  localparam ctrl_word_t PROGRAM [PROG_DEPTH] = '{
    '{op: OP_LOAD,   cond: C_IDLE_WAIT,    jump: STEP_IDLE,   next: STEP_DIV},
    '{op: OP_DIV,    cond: C_NEVER,        jump: STEP_IDLE,   next: STEP_QSTART},
    '{op: OP_QSTART, cond: C_NEVER,        jump: STEP_IDLE,   next: STEP_PAIR},
    '{op: OP_EVAL,   cond: C_DIME_MORE,    jump: STEP_PAIR,   next: STEP_QNEXT},
    '{op: OP_QNEXT,  cond: C_QUARTER_MORE, jump: STEP_QSTART, next: STEP_EMIT},
    '{op: OP_EMIT,   cond: C_OUT_BUSY,     jump: STEP_EMIT,   next: STEP_IDLE},
    '{op: OP_NOP,    cond: C_ALWAYS,       jump: STEP_IDLE,   next: STEP_IDLE},
    '{op: OP_NOP,    cond: C_ALWAYS,       jump: STEP_IDLE,   next: STEP_IDLE}
  };

endpackage

// ===== rtl/bcc_if.sv =====
// Valid/ready channel interfaces for the bounded coin change block.
// Input channel carries the amount and coin stocks; output carries the best mix.
// No package dependencies.
`timescale 1ns / 1ps

interface bcc_item_if #(
  parameter int AMOUNT_BITS = 16,
  parameter int COUNT_BITS  = 10
);
  logic                   valid;
  logic                   ready;
  logic [AMOUNT_BITS-1:0] amount;
  logic [COUNT_BITS-1:0]  pennies_held;
  logic [COUNT_BITS-1:0]  nickels_held;
  logic [COUNT_BITS-1:0]  dimes_held;
  logic [COUNT_BITS-1:0]  quarters_held;

  modport source (output valid, amount, pennies_held, nickels_held, dimes_held,
                  quarters_held, input ready);
  modport sink   (input valid, amount, pennies_held, nickels_held, dimes_held,
                  quarters_held, output ready);
endinterface

interface bcc_result_if #(
  parameter int COUNT_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [COUNT_BITS-1:0] pennies_used;
  logic [COUNT_BITS-1:0] nickels_used;
  logic [COUNT_BITS-1:0] dimes_used;
  logic [COUNT_BITS-1:0] quarters_used;

  modport source (output valid, found, pennies_used, nickels_used, dimes_used,
                  quarters_used, input ready);
  modport sink   (input valid, found, pennies_used, nickels_used, dimes_used,
                  quarters_used, output ready);
endinterface

// ===== rtl/bcc_datapath.sv =====
// Datapath of the bounded coin change block: divide-by-five unit, quarter and
// dime loop registers, candidate stage and best-mix registers.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_datapath
  import bcc_pkg::*;
#(
  parameter int AMOUNT_BITS = 16,
  parameter int COUNT_BITS  = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  op_t                    op,
  input  logic [AMOUNT_BITS-1:0] amount,
  input  logic [COUNT_BITS-1:0]  pennies_held,
  input  logic [COUNT_BITS-1:0]  nickels_held,
  input  logic [COUNT_BITS-1:0]  dimes_held,
  input  logic [COUNT_BITS-1:0]  quarters_held,
  output dp_flags_t              flags,
  output logic                   found,
  output logic [COUNT_BITS-1:0]  pennies_used,
  output logic [COUNT_BITS-1:0]  nickels_used,
  output logic [COUNT_BITS-1:0]  dimes_used,
  output logic [COUNT_BITS-1:0]  quarters_used
);

  localparam int FIVE_W = COUNT_BITS + 3;
  localparam int W      = (AMOUNT_BITS > FIVE_W) ? AMOUNT_BITS : FIVE_W;
  localparam int TW     = COUNT_BITS + 2;

  // Reciprocal of five scaled by 2^RECIP_SHIFT, rounded up; the quotient is
  // exact for every dividend below 2^AMOUNT_BITS
  localparam int                     RECIP_SHIFT = AMOUNT_BITS + 2;
  localparam logic [63:0]            RECIP_WIDE  = ((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5;
  localparam logic [AMOUNT_BITS-1:0] RECIP5      = RECIP_WIDE[AMOUNT_BITS-1:0];

  // Latched stocks
  logic [COUNT_BITS-1:0]  p_held, n_held, d_held, q_held;
  logic [FIVE_W-1:0]      five_n;

  // Divider and loop registers
  logic [AMOUNT_BITS-1:0] fives_q;   // amount before the divide, then after_q / 5
  logic [2:0]             rem5;
  logic [AMOUNT_BITS-1:0] after_q, after_d, fives_d;
  logic [COUNT_BITS-1:0]  qc, dc;

  // Candidate stage
  logic                   cand_valid, cand_ok;
  logic [COUNT_BITS-1:0]  cand_q, cand_d, cand_n, cand_p;

  // Best mix
  logic                   have;
  logic [TW-1:0]          best_total;
  logic [COUNT_BITS-1:0]  best_q, best_d, best_n, best_p;

  // Divide step
  logic [2*AMOUNT_BITS-1:0] recip_prod;
  logic [AMOUNT_BITS-1:0]   fives_div;
  logic [2:0]               rem5_next;

  // Candidate evaluation
  logic [W-1:0]           fives_w, pc_wide;
  logic                   fives_le, eval_ok;
  logic [COUNT_BITS-1:0]  eval_n, eval_p;
  logic [TW-1:0]          cand_total;
  logic                   take_best;

  // Divide by five with a reciprocal multiply; the remainder only needs the
  // low three bits of after_q - 5 * (after_q / 5)
  always_comb begin
    recip_prod = (2*AMOUNT_BITS)'(fives_q) * (2*AMOUNT_BITS)'(RECIP5);
    fives_div  = AMOUNT_BITS'(recip_prod[2*AMOUNT_BITS-1:RECIP_SHIFT]);
    rem5_next  = after_q[2:0] - ({fives_q[0], 2'b00} + fives_q[2:0]);
  end

  // Use all the nickels that fit; pennies make up the rest
  always_comb begin
    fives_w  = W'(fives_d);
    pc_wide  = W'(after_d) - W'(five_n);
    fives_le = fives_w <= W'(n_held);
    if (fives_le) begin
      eval_n  = fives_w[COUNT_BITS-1:0];
      eval_p  = COUNT_BITS'(rem5);
      eval_ok = W'(rem5) <= W'(p_held);
    end else begin
      eval_n  = n_held;
      eval_p  = pc_wide[COUNT_BITS-1:0];
      eval_ok = pc_wide <= W'(p_held);
    end
  end

  // Strictly smaller total replaces the best so far
  always_comb begin
    cand_total = TW'(cand_q) + TW'(cand_d) + TW'(cand_n) + TW'(cand_p);
    take_best  = cand_valid && cand_ok && (!have || (cand_total < best_total));
  end

  // Loop continuation
  always_comb begin
    flags.dime_more    = (dc < d_held) && (after_d >= AMOUNT_BITS'(CENTS_DIME));
    flags.quarter_more = (qc < q_held) && (after_q >= AMOUNT_BITS'(CENTS_QUARTER));
  end

  // Mark a candidate after every evaluation step
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= op == OP_EVAL;
    end
  end

  // Loop registers and candidate stage
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        p_held  <= pennies_held;
        n_held  <= nickels_held;
        d_held  <= dimes_held;
        q_held  <= quarters_held;
        five_n  <= (FIVE_W'(nickels_held) << 2) + FIVE_W'(nickels_held);
        fives_q <= amount;
        after_q <= amount;
        qc      <= '0;
      end
      OP_DIV: begin
        fives_q <= fives_div;
      end
      OP_QSTART: begin
        after_d <= after_q;
        fives_d <= fives_q;
        rem5    <= rem5_next;
        dc      <= '0;
      end
      OP_EVAL: begin
        cand_ok    <= eval_ok;
        cand_q     <= qc;
        cand_d     <= dc;
        cand_n     <= eval_n;
        cand_p     <= eval_p;
        if (flags.dime_more) begin
          dc      <= dc + 1'b1;
          after_d <= after_d - AMOUNT_BITS'(CENTS_DIME);
          fives_d <= fives_d - AMOUNT_BITS'(2);
        end
      end
      OP_QNEXT: begin
        if (flags.quarter_more) begin
          qc      <= qc + 1'b1;
          after_q <= after_q - AMOUNT_BITS'(CENTS_QUARTER);
          fives_q <= fives_q - AMOUNT_BITS'(CENTS_NICKEL);
        end
      end
      default: begin
      end
    endcase
  end

  // Best-mix registers, cleared on each new transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (op == OP_LOAD) begin
      have       <= 1'b0;
      best_total <= '0;
      best_q     <= '0;
      best_d     <= '0;
      best_n     <= '0;
      best_p     <= '0;
    end else if (take_best) begin
      have       <= 1'b1;
      best_total <= cand_total;
      best_q     <= cand_q;
      best_d     <= cand_d;
      best_n     <= cand_n;
      best_p     <= cand_p;
    end
  end

  assign found         = have;
  assign pennies_used  = best_p;
  assign nickels_used  = best_n;
  assign dimes_used    = best_d;
  assign quarters_used = best_q;

endmodule

// ===== rtl/bounded_coin_change.sv =====
// Top level of the bounded coin change block: microcode sequencer and result
// register around bcc_datapath.
// Depends on bcc_pkg, bcc_if and bcc_datapath.
`timescale 1ns / 1ps

// Finds the mix of pennies, nickels, dimes and quarters with the fewest coins
// that pays an amount exactly from limited stocks, trying quarter counts and
// then dime counts from zero upward; the first minimum found wins. One
// transaction is worked at a time. A transaction is accepted, the amount is
// divided by five with a reciprocal multiply, then for each quarter count Q
// from 0 to min(quarters_held, amount/25) there is a setup step, one trial
// per dime count from 0 to min(dimes_held, (amount-25Q)/10) and a closing
// step, and finally the result register is loaded, the transaction waiting
// for it while an earlier result still waits. The dime loop of the
// sequencer runs one trial per cycle. The result register lets the next
// transaction be accepted while a result waits to be taken.
module bounded_coin_change
  import bcc_pkg::*;
#(
  parameter int AMOUNT_BITS = 16,
  parameter int COUNT_BITS  = 10
) (
  input logic         clk,
  input logic         rst,
  bcc_item_if.sink    item,
  bcc_result_if.source result
);

  step_t      step;
  ctrl_word_t word;
  dp_flags_t  flags;
  op_t        dp_op;
  logic       item_fire, out_busy, emit_go, jump_taken;

  logic                  dp_found;
  logic [COUNT_BITS-1:0] dp_p, dp_n, dp_d, dp_q;

  logic                  out_valid, out_found;
  logic [COUNT_BITS-1:0] out_p, out_n, out_d, out_q;

  // Fetch the control word
  always_comb begin
    word      = PROGRAM[step];
    item_fire = item.valid && item.ready;
    out_busy  = out_valid && !result.ready;
    emit_go   = (word.op == OP_EMIT) && !out_busy;
    dp_op     = ((word.op == OP_LOAD) && !item_fire) ? OP_NOP : word.op;
  end

  assign item.ready = word.op == OP_LOAD;

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      C_NEVER:        jump_taken = 1'b0;
      C_ALWAYS:       jump_taken = 1'b1;
      C_IDLE_WAIT:    jump_taken = !item_fire;
      C_DIME_MORE:    jump_taken = flags.dime_more;
      C_QUARTER_MORE: jump_taken = flags.quarter_more;
      C_OUT_BUSY:     jump_taken = out_busy;
      default:        jump_taken = 1'b1;
    endcase
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= jump_taken ? word.jump : word.next;
    end
  end

  bcc_datapath #(
    .AMOUNT_BITS (AMOUNT_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .op            (dp_op),
    .amount        (item.amount),
    .pennies_held  (item.pennies_held),
    .nickels_held  (item.nickels_held),
    .dimes_held    (item.dimes_held),
    .quarters_held (item.quarters_held),
    .flags         (flags),
    .found         (dp_found),
    .pennies_used  (dp_p),
    .nickels_used  (dp_n),
    .dimes_used    (dp_d),
    .quarters_used (dp_q)
  );

  // Hold the result until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (emit_go) begin
      out_found <= dp_found;
      out_p     <= dp_p;
      out_n     <= dp_n;
      out_d     <= dp_d;
      out_q     <= dp_q;
    end
  end

  assign result.valid         = out_valid;
  assign result.found         = out_found;
  assign result.pennies_used  = out_p;
  assign result.nickels_used  = out_n;
  assign result.dimes_used    = out_d;
  assign result.quarters_used = out_q;

endmodule

// ===== verif/coin_mix_checker.sv =====
// Checker for the bounded coin change block: taps both channels, predicts the
// fewest-coin mix for every accepted request and compares it with each result.
// Depends on bcc_pkg (coin values) and the channel interfaces in bcc_if.
`timescale 1ns / 1ps

module coin_mix_checker
  import bcc_pkg::*;
#(
  parameter int AMOUNT_BITS = 16,
  parameter int COUNT_BITS  = 10
) (
  input  logic        clk,
  input  logic        rst,
  bcc_item_if         item_tap,
  bcc_result_if       result_tap,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned results_checked,
  output int unsigned payable_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                  found;
    logic [COUNT_BITS-1:0] pennies;
    logic [COUNT_BITS-1:0] nickels;
    logic [COUNT_BITS-1:0] dimes;
    logic [COUNT_BITS-1:0] quarters;
  } coin_mix_t;

  coin_mix_t   expected_mixes [$];
  int unsigned fails    = 0;
  int unsigned checked  = 0;
  int unsigned payable  = 0;
  int unsigned reported = 0;

  // Walk quarters, then dimes, from zero up; greedy nickels, pennies for the rest.
  // Keep a mix only when its coin total is strictly below the best so far.
  function automatic coin_mix_t fewest_coins(input logic [AMOUNT_BITS-1:0] amt,
                                             input logic [COUNT_BITS-1:0]  p_stock,
                                             input logic [COUNT_BITS-1:0]  n_stock,
                                             input logic [COUNT_BITS-1:0]  d_stock,
                                             input logic [COUNT_BITS-1:0]  q_stock);
    coin_mix_t   best;
    int unsigned best_total;
    int unsigned q_top, d_top, after_q, after_d;
    int unsigned qc, dc, nc, pc, total;
    best       = '0;
    best_total = 0;
    q_top      = amt / CENTS_QUARTER;
    if (q_stock < q_top) q_top = q_stock;
    for (qc = 0; qc <= q_top; qc++) begin
      after_q = amt - qc * CENTS_QUARTER;
      d_top   = after_q / CENTS_DIME;
      if (d_stock < d_top) d_top = d_stock;
      for (dc = 0; dc <= d_top; dc++) begin
        after_d = after_q - dc * CENTS_DIME;
        nc      = after_d / CENTS_NICKEL;
        if (n_stock < nc) nc = n_stock;
        pc      = after_d - nc * CENTS_NICKEL;
        if (pc <= p_stock) begin
          total = qc + dc + nc + pc;
          if (!best.found || total < best_total) begin
            best_total    = total;
            best.found    = 1'b1;
            best.pennies  = COUNT_BITS'(pc);
            best.nickels  = COUNT_BITS'(nc);
            best.dimes    = COUNT_BITS'(dc);
            best.quarters = COUNT_BITS'(qc);
          end
        end
      end
    end
    return best;
  endfunction

  // Compare results against the oldest prediction, then queue new predictions
  always @(posedge clk) begin
    coin_mix_t want;
    coin_mix_t got;
    if (!rst) begin
      if (result_tap.valid && result_tap.ready) begin
        got.found    = result_tap.found;
        got.pennies  = result_tap.pennies_used;
        got.nickels  = result_tap.nickels_used;
        got.dimes    = result_tap.dimes_used;
        got.quarters = result_tap.quarters_used;
        if (expected_mixes.size() == 0) begin
          fails++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("ERROR: unexpected result found=%0d p=%0d n=%0d d=%0d q=%0d",
                     got.found, got.pennies, got.nickels, got.dimes, got.quarters);
          end
        end else begin
          want = expected_mixes.pop_front();
          if (got.found !== want.found || got.pennies !== want.pennies ||
              got.nickels !== want.nickels || got.dimes !== want.dimes ||
              got.quarters !== want.quarters) begin
            fails++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("ERROR: result %0d expected found=%0d p=%0d n=%0d d=%0d q=%0d",
                       checked, want.found, want.pennies, want.nickels, want.dimes,
                       want.quarters);
              $display("       got                found=%0d p=%0d n=%0d d=%0d q=%0d",
                       got.found, got.pennies, got.nickels, got.dimes, got.quarters);
            end
          end
          if (want.found) payable++;
          checked++;
        end
      end
      if (item_tap.valid && item_tap.ready)
        expected_mixes.push_back(fewest_coins(item_tap.amount, item_tap.pennies_held,
                                              item_tap.nickels_held, item_tap.dimes_held,
                                              item_tap.quarters_held));
    end
    fail_count      <= fails;
    pending         <= expected_mixes.size();
    results_checked <= checked;
    payable_count   <= payable;
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the bounded coin change block: clock, reset, request and
// result channel drivers, watchdog and verdict.
// Depends on bcc_pkg, bcc_if, bounded_coin_change and coin_mix_checker.
`timescale 1ns / 1ps

module tb;

  localparam int AMOUNT_BITS     = 16;
  localparam int COUNT_BITS      = 10;
  localparam int RANDOM_REQUESTS = 1000;
  localparam int PRESSURE_AT     = 300;
  localparam int HOLD_CYCLES     = 1500;
  localparam int QUIET_FROM      = 600;
  localparam int QUIET_TO        = 700;
  localparam int STALL_LIMIT     = 100000;
  localparam int DRAIN_CYCLES    = 40;

  logic        clk;
  logic        rst;
  bit          no_gaps       = 1'b0;
  int unsigned holds_asked   = 0;
  int unsigned holds_done    = 0;
  int unsigned requests_sent = 0;
  int unsigned directed_sent = 0;
  int unsigned idle_cycles   = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned payable_count;

  bcc_item_if #(.AMOUNT_BITS(AMOUNT_BITS), .COUNT_BITS(COUNT_BITS)) item_ch ();
  bcc_result_if #(.COUNT_BITS(COUNT_BITS)) result_ch ();

  bounded_coin_change #(
    .AMOUNT_BITS(AMOUNT_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  coin_mix_checker #(
    .AMOUNT_BITS(AMOUNT_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .item_tap       (item_ch),
    .result_tap     (result_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .payable_count  (payable_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // End the run when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Watchdog: no transaction in %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input logic [AMOUNT_BITS-1:0] amt,
                              input logic [COUNT_BITS-1:0]  p,
                              input logic [COUNT_BITS-1:0]  n,
                              input logic [COUNT_BITS-1:0]  d,
                              input logic [COUNT_BITS-1:0]  q);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.amount        <= amt;
    item_ch.pennies_held  <= p;
    item_ch.nickels_held  <= n;
    item_ch.dimes_held    <= d;
    item_ch.quarters_held <= q;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Mostly small amounts and tight stocks; a few full-width requests with
  // one of the quarter or dime stocks kept small to bound the search
  task automatic send_random_request(input bit allow_wide);
    logic [AMOUNT_BITS-1:0] amt;
    logic [COUNT_BITS-1:0]  p, n, d, q;
    int unsigned            shape;
    shape = $urandom_range(0, 99);
    if (allow_wide && shape < 2) begin
      amt = AMOUNT_BITS'($urandom_range(0, 65535));
      p   = COUNT_BITS'($urandom_range(0, 1023));
      n   = COUNT_BITS'($urandom_range(0, 1023));
      if ($urandom_range(0, 1) == 0) begin
        q = COUNT_BITS'($urandom_range(0, 1023));
        d = COUNT_BITS'($urandom_range(0, 15));
      end else begin
        q = COUNT_BITS'($urandom_range(0, 15));
        d = COUNT_BITS'($urandom_range(0, 1023));
      end
    end else begin
      amt = (shape < 12) ? AMOUNT_BITS'($urandom_range(0, 30))
                         : AMOUNT_BITS'($urandom_range(0, 400));
      p   = ($urandom_range(0, 3) == 0) ? COUNT_BITS'($urandom_range(0, 1023))
                                        : COUNT_BITS'($urandom_range(0, 12));
      n   = ($urandom_range(0, 3) == 0) ? COUNT_BITS'($urandom_range(0, 1023))
                                        : COUNT_BITS'($urandom_range(0, 12));
      d   = COUNT_BITS'($urandom_range(0, 30));
      q   = COUNT_BITS'($urandom_range(0, 16));
    end
    send_request(amt, p, n, d, q);
  endtask

  // Result side: random stalls, plus one long hold-off when asked
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (holds_asked != holds_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid && holds_asked == holds_done) @(posedge clk);
    end
  end

  // Request side: reset, directed requests, random requests, drain, verdict
  initial begin
    int unsigned i;
    rst                   = 1'b1;
    item_ch.valid         = 1'b0;
    item_ch.amount        = '0;
    item_ch.pennies_held  = '0;
    item_ch.nickels_held  = '0;
    item_ch.dimes_held    = '0;
    item_ch.quarters_held = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Zero amount, with empty and with full stocks
    send_request(0, 0, 0, 0, 0);
    send_request(0, 1023, 1023, 1023, 1023);
    // Not enough change
    send_request(1, 0, 1023, 1023, 1023);
    send_request(3, 2, 0, 0, 0);
    send_request(7, 1, 1, 0, 0);
    send_request(65535, 1023, 0, 0, 0);
    // Each count at its maximum in the result
    send_request(1023, 1023, 0, 0, 0);
    send_request(5115, 0, 1023, 0, 0);
    send_request(10230, 0, 0, 1023, 0);
    send_request(25575, 0, 0, 0, 1023);
    // Largest amount with deep quarter or dime searches, then full stocks
    send_request(65535, 1023, 1023, 0, 1023);
    send_request(65535, 1023, 1023, 1023, 0);
    send_request(1023, 1023, 1023, 1023, 1023);
    // Limited stocks, some where taking quarters first is not the best
    send_request(30, 5, 0, 3, 1);
    send_request(40, 15, 0, 4, 1);
    send_request(65, 0, 0, 4, 3);
    send_request(30, 0, 1, 0, 1);
    send_request(6, 1, 1, 0, 0);
    send_request(99, 4, 1, 2, 3);
    directed_sent = requests_sent;

    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      // Pause until drained, then let the receiver hold off while requests pile up
      if (i == PRESSURE_AT) begin
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        holds_asked++;
      end
      no_gaps = (i >= QUIET_FROM && i < QUIET_TO);
      send_random_request(!(i >= PRESSURE_AT && i < PRESSURE_AT + 12));
    end
    item_ch.valid <= 1'b0;

    // Drain outstanding results, then watch a little longer for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d change requests (%0d directed, the rest random), checked %0d results",
             requests_sent, directed_sent, results_checked);
    $display("%0d payable, %0d short of change; included a long result hold-off and a drain",
             payable_count, results_checked - payable_count);
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bcc_pkg.sv
rtl/bcc_if.sv
rtl/bcc_datapath.sv
rtl/bounded_coin_change.sv
verif/coin_mix_checker.sv
verif/tb.sv
